/* rtl/atl_pkg.sv */
package atl_pkg;

  localparam int unsigned RawW  = 33;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;

  localparam logic [CfgW-1:0] JumpLimitReset = 16'd1000;
  localparam logic [CfgW-1:0] SeekGapReset   = 16'd40;

  typedef enum logic [1:0] {
    FUNC_AUDIO  = 2'd0,
    FUNC_VIDEO  = 2'd1,
    FUNC_SEEK   = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_FORWARD  = 3'd0,
    ST_FIRST    = 3'd1,
    ST_RESYNC   = 3'd2,
    ST_JUMP     = 3'd3,
    ST_BACKWARD = 3'd4
  } status_t;

  typedef enum logic {
    CFG_JUMP_LIMIT = 1'b0,
    CFG_SEEK_GAP   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]      func;
    logic [RawW-1:0] raw_pts;
  } in_item_t;

  typedef struct packed {
    logic [TimeW-1:0] linear_time;
    logic [2:0]       status;
  } out_item_t;

  typedef struct packed {
    logic                       first_pending;
    logic [1:0][TimeW-1:0]      running_time;
    logic [1:0][RawW-1:0]       last_raw;
    logic [1:0][RawW-1:0]       resync_time;
  } atl_state_t;

  typedef struct packed {
    logic [CfgW-1:0] jump_limit;
    logic [CfgW-1:0] seek_gap;
  } atl_cfg_t;

endpackage

/* rtl/atl_step.sv */
module atl_step
  import atl_pkg::*;
(
  input  atl_cfg_t   cfg,
  input  atl_state_t cur,
  input  in_item_t   item,
  output atl_state_t nxt,
  output logic       has_result,
  output out_item_t  result
);

  logic            sel;
  logic            oth;
  logic [RawW-1:0] prev;
  logic [RawW-1:0] fwd_diff;
  logic [RawW-1:0] step_mag;
  logic            is_fwd;
  logic            is_jump;
  logic [TimeW-1:0] big;
  logic [RawW-1:0] resync_v;
  status_t         status;

  assign sel      = item.func[0];
  assign oth      = ~sel;
  assign prev     = cur.last_raw[sel];
  assign is_fwd   = item.raw_pts >= prev;
  assign fwd_diff = item.raw_pts - prev;
  assign step_mag = is_fwd ? fwd_diff : (prev - item.raw_pts);
  assign is_jump  = step_mag > {{(RawW-CfgW){1'b0}}, cfg.jump_limit};
  assign big      = (cur.running_time[0] > cur.running_time[1]) ?
                    cur.running_time[0] : cur.running_time[1];
  assign resync_v = {1'b0, big} + {{(RawW-CfgW){1'b0}}, cfg.seek_gap};

  always_comb begin
    nxt        = cur;
    has_result = 1'b0;
    status     = ST_FORWARD;
    case (func_t'(item.func))
      FUNC_AUDIO, FUNC_VIDEO: begin
        has_result         = 1'b1;
        nxt.last_raw[sel]  = item.raw_pts;
        if (cur.first_pending) begin
          nxt.first_pending     = 1'b0;
          nxt.running_time[sel] = '0;
          status                = ST_FIRST;
        end else if (cur.resync_time[sel] != '0) begin
          nxt.running_time[sel] = cur.resync_time[sel][TimeW-1:0];
          nxt.resync_time[sel]  = '0;
          status                = ST_RESYNC;
        end else if (is_jump) begin
          nxt.running_time[sel] = resync_v[TimeW-1:0];
          nxt.resync_time[sel]  = '0;
          nxt.resync_time[oth]  = resync_v;
          status                = ST_JUMP;
        end else if (is_fwd) begin
          nxt.running_time[sel] = cur.running_time[sel] + fwd_diff[TimeW-1:0];
          status                = ST_FORWARD;
        end else begin
          status = ST_BACKWARD;
        end
      end
      FUNC_SEEK: begin
        nxt.resync_time[0] = resync_v;
        nxt.resync_time[1] = resync_v;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign result.linear_time = nxt.running_time[sel];
  assign result.status      = status;

endmodule

/* rtl/av_timestamp_linearizer_core.sv */
// A request is registered in stage 1; its result is written to the output register when stage 1 advances.
// One request per cycle unless a held output stalls it; the stream state is read and rewritten in the same cycle.
// Seek events update the resync times only, unused selectors leave state unchanged; neither gives a result.
// Reset (rst_n low, synchronous) empties both stages, restores the register defaults
// and returns the stream state to its initial values, with the first-item flag set.
module av_timestamp_linearizer_core
  import atl_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_item,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_wdata
);

  atl_cfg_t   cfg_r;
  atl_state_t st_r;
  atl_state_t st_nxt;
  in_item_t   s1_item_r;
  logic       s1_vld_r;
  out_item_t  out_item_r;
  logic       out_vld_r;
  logic       has_result;
  out_item_t  result;
  logic       out_free;
  logic       adv;

  atl_step u_step (
    .cfg        (cfg_r),
    .cur        (st_r),
    .item       (s1_item_r),
    .nxt        (st_nxt),
    .has_result (has_result),
    .result     (result)
  );

  assign out_free  = !out_vld_r || out_ready;
  assign adv       = s1_vld_r && (!has_result || out_free);
  assign in_ready  = !s1_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jump_limit <= JumpLimitReset;
      cfg_r.seek_gap   <= SeekGapReset;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_JUMP_LIMIT: cfg_r.jump_limit <= cfg_wdata;
        CFG_SEEK_GAP:   cfg_r.seek_gap   <= cfg_wdata;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{first_pending: 1'b1, running_time: '0, last_raw: '0, resync_time: '0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= adv && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      out_item_r <= result;
    end
  end

endmodule
